// ===== design/pds_pkg.sv =====
// pds_pkg: shared types, character constants and helper functions for the
// percent decoder. No dependencies.
package pds_pkg;

  // Decode modes held in the decode_mode register
  localparam logic [1:0] MODE_SPACES    = 2'd0;
  localparam logic [1:0] MODE_URI       = 2'd1;
  localparam logic [1:0] MODE_COMPONENT = 2'd2;
  localparam logic [1:0] MODE_ALL       = 2'd3;
  localparam logic [1:0] DECODE_MODE_RESET = MODE_ALL;

  // Register byte addresses
  localparam logic [1:0] ADDR_DECODE_MODE = 2'd0;

  // Characters
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Index of the final byte in a job
  localparam logic [1:0] LAST_ONE   = 2'd0;
  localparam logic [1:0] LAST_TWO   = 2'd1;
  localparam logic [1:0] LAST_THREE = 2'd2;

  // One classified input: up to three output bytes, sent bytes[0] first
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            text_end;
  } job_t;

  // Hex digit value; bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

  // Upper-case ASCII letters
  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h20;
    return r;
  endfunction

  // Unreserved marks kept by both uri modes
  function automatic logic kept_component(input logic [7:0] v);
    logic r;
    case (v) inside
      8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Reserved characters kept only by the full uri mode
  function automatic logic kept_uri_extra(input logic [7:0] v);
    logic r;
    case (v) inside
      8'h23, 8'h24, 8'h26, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F,
      8'h40: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/pds_ifs.sv =====
// pds_ifs: valid/ready stream interfaces for the encoded input bytes and the
// decoded output bytes. No dependencies.
interface pds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_end;
  modport source(output valid, output in_char, output in_end, input ready);
  modport sink(input valid, input in_char, input in_end, output ready);
endinterface

interface pds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_run_last;
  logic       out_text_end;
  modport source(output valid, output out_char, output out_run_last,
                 output out_text_end, input ready);
  modport sink(input valid, input out_char, input out_run_last,
               input out_text_end, output ready);
endinterface

// ===== design/percent_decode_stream.sv =====
// percent_decode_stream: top level of the streaming percent decoder; holds
// the decode_mode register. Uses pds_pkg, pds_ifs, pds_front/queue/back.
//
//   channel      dir  handshake           payload
//   in_stream    in   valid/ready         in_char[7:0], in_end
//   out_stream   out  valid/ready         out_char[7:0], out_run_last,
//                                         out_text_end
//   apb          in   psel/penable/pready paddr[1:0], pwdata/prdata[31:0]
//
// An input byte is accepted each cycle while the job queue has room. A job
// yields one output byte per cycle while out_stream is ready, so a kept
// escape holds the output register for its three bytes; the queue
// (QUEUE_DEPTH jobs) absorbs that. A byte is queued, then registered out.
// rst clears the escape state, queue, output valid and sets decode_mode to 3.
module percent_decode_stream #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  pds_in_if.sink      in_stream,
  pds_out_if.source   out_stream,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]    decode_mode;
  logic          q_full;
  logic          job_push;
  pds_pkg::job_t job;
  logic          head_valid;
  pds_pkg::job_t head;
  logic          pop;

  assign pready = 1'b1;
  assign prdata = (paddr == pds_pkg::ADDR_DECODE_MODE) ? {30'd0, decode_mode} : 32'd0;

  // Write the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= pds_pkg::DECODE_MODE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == pds_pkg::ADDR_DECODE_MODE) begin
      decode_mode <= pwdata[1:0];
    end
  end

  pds_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_stream   (in_stream),
    .decode_mode (decode_mode),
    .q_full      (q_full),
    .job_push    (job_push),
    .job         (job)
  );

  pds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  pds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_stream (out_stream)
  );

endmodule

// ===== design/pds_front.sv =====
// pds_front: accepts encoded bytes, tracks the escape state and emits a
// job of 1-3 output bytes per byte or escape. Uses pds_pkg, pds_in_if.
module pds_front (
  input  logic             clk,
  input  logic             rst,
  pds_in_if.sink           in_stream,
  input  logic [1:0]       decode_mode,
  input  logic             q_full,
  output logic             job_push,
  output pds_pkg::job_t    job
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] held;
  logic [7:0] held_next;
  logic       accept;
  logic       job_valid;
  logic [4:0] hi;
  logic [4:0] lo;
  logic [7:0] value;
  logic       decode;
  logic [7:0] c;
  logic       last;

  assign in_stream.ready = !q_full;
  assign accept   = in_stream.valid && in_stream.ready;
  assign c        = in_stream.in_char;
  assign last     = in_stream.in_end;
  assign job_push = accept && job_valid;

  // Decode the escape digits and apply the mode's keep rules
  assign hi    = pds_pkg::hex_nibble(held);
  assign lo    = pds_pkg::hex_nibble(c);
  assign value = {hi[3:0], lo[3:0]};

  always_comb begin
    if (hi[4] || lo[4]) begin
      decode = 1'b0;
    end else begin
      unique case (decode_mode)
        pds_pkg::MODE_SPACES:    decode = (value == pds_pkg::CH_SPACE);
        pds_pkg::MODE_URI:       decode = !pds_pkg::kept_component(value) &&
                                          !pds_pkg::kept_uri_extra(value);
        pds_pkg::MODE_COMPONENT: decode = !pds_pkg::kept_component(value);
        default:                 decode = 1'b1;
      endcase
    end
  end

  // Classify the current byte
  always_comb begin
    phase_next    = phase;
    held_next     = held;
    job_valid     = 1'b0;
    job.bytes     = {8'h00, 8'h00, c};
    job.last_idx  = pds_pkg::LAST_ONE;
    job.text_end  = last;
    unique case (phase)
      PH_PCT: begin
        if (last) begin
          job_valid   = 1'b1;
          job.bytes   = {8'h00, c, pds_pkg::CH_PERCENT};
          job.last_idx = pds_pkg::LAST_TWO;
        end else begin
          phase_next = PH_DIGIT;
          held_next  = c;
        end
      end
      PH_DIGIT: begin
        job_valid  = 1'b1;
        phase_next = PH_IDLE;
        held_next  = 8'h00;
        if (decode) begin
          job.bytes = {8'h00, 8'h00, value};
        end else begin
          job.bytes    = {pds_pkg::upcase(c), pds_pkg::upcase(held),
                          pds_pkg::CH_PERCENT};
          job.last_idx = pds_pkg::LAST_THREE;
        end
      end
      default: begin
        if (c == pds_pkg::CH_PERCENT && !last) begin
          phase_next = PH_PCT;
        end else begin
          phase_next = PH_IDLE;
          job_valid  = 1'b1;
        end
      end
    endcase
    if (last) begin
      phase_next = PH_IDLE;
      held_next  = 8'h00;
    end
  end

  // Advance the escape state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= 8'h00;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

// ===== design/pds_queue.sv =====
// pds_queue: small register FIFO of jobs between the front and back parts.
// Uses pds_pkg.
module pds_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pds_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output pds_pkg::job_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  pds_pkg::job_t slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = slots[rptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == LAST_SLOT) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == LAST_SLOT) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== design/pds_back.sv =====
// pds_back: walks the bytes of each queued job into a registered output
// stage. Uses pds_pkg, pds_out_if.
module pds_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  pds_pkg::job_t head,
  output logic          pop,
  pds_out_if.source     out_stream
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_run_last;
  logic       out_text_end;

  assign load    = !out_valid || out_stream.ready;
  assign is_last = (idx == head.last_idx);
  assign pop     = load && head_valid && is_last;

  assign out_stream.valid        = out_valid;
  assign out_stream.out_char     = out_char;
  assign out_stream.out_run_last = out_run_last;
  assign out_stream.out_text_end = out_text_end;

  // Hold the output register until taken; step through the job's bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_char     <= head.bytes[idx];
      out_run_last <= is_last;
      out_text_end <= is_last && head.text_end;
    end
  end

endmodule
